@@ sv/ecdsa_pkg.sv @@
package ecdsa_pkg;

    localparam int COORD_BITS_DEF = 30;
    localparam int ORDER_BITS_DEF = 31;

    // Largest and smallest legal moduli
    localparam logic [63:0] MAX_FIELD = 64'd1073741789;
    localparam logic [63:0] MAX_ORDER = 64'd1073807325;
    localparam logic [63:0] MIN_MOD   = 64'd5;

    // Register reset values
    localparam logic [63:0] CURVE_A_RST     = 64'd355;
    localparam logic [63:0] CURVE_B_RST     = 64'd671;
    localparam logic [63:0] FIELD_PRIME_RST = 64'd1073741789;
    localparam logic [63:0] BASE_X_RST      = 64'd13693;
    localparam logic [63:0] BASE_Y_RST      = 64'd10088;
    localparam logic [63:0] GROUP_ORDER_RST = 64'd1073807281;

    // Register indexes
    localparam logic [2:0] REG_CURVE_A     = 3'd0;
    localparam logic [2:0] REG_CURVE_B     = 3'd1;
    localparam logic [2:0] REG_FIELD_PRIME = 3'd2;
    localparam logic [2:0] REG_BASE_X      = 3'd3;
    localparam logic [2:0] REG_BASE_Y      = 3'd4;
    localparam logic [2:0] REG_GROUP_ORDER = 3'd5;

    // Status codes
    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_DOMAIN   = 2'd2;
    localparam logic [1:0] ST_NOINV    = 2'd3;

endpackage

@@ sv/ecdsa_signature_verify.sv @@
// Channel  | Direction | Handshake            | Beat contents
// ---------+-----------+----------------------+-----------------------------------------------
// in       | input     | in_valid / in_ready  | pubkey_x, pubkey_y, pubkey_at_infinity,
//          |           |                      | message_hash, sig_c, sig_d
// out      | output    | out_valid/out_ready  | status, recomputed_c
// cfg      | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One beat is processed by the shared bit-serial modular multiplier (up to four products
// per point operation) and the Euclidean inverter, over up to 4*ORDER_BITS+1 point ops.
// Out-of-domain beats go straight to the emit step. in_ready is high only in idle.
// A finished result waits in the output register; the next beat is taken meanwhile.
// rst_n clears control state and loads the register reset values; cfg_ready is always high.
module ecdsa_signature_verify #(
    parameter int COORD_BITS = ecdsa_pkg::COORD_BITS_DEF,
    parameter int ORDER_BITS = ecdsa_pkg::ORDER_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] pubkey_x,
    input  logic [COORD_BITS-1:0] pubkey_y,
    input  logic                  pubkey_at_infinity,
    input  logic [ORDER_BITS-1:0] message_hash,
    input  logic [ORDER_BITS-1:0] sig_c,
    input  logic [ORDER_BITS-1:0] sig_d,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [ORDER_BITS-1:0] recomputed_c,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [((ORDER_BITS > COORD_BITS) ? ORDER_BITS : COORD_BITS)-1:0] cfg_data
);

    localparam int VW = (ORDER_BITS > COORD_BITS) ? ORDER_BITS : COORD_BITS;
    localparam int SW = VW + 2;
    localparam int CW = $clog2(VW + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_PREP, S_PREP_WR, S_HINV, S_H1, S_H2, S_H3,
        S_MLOOP, S_MACC, S_MDBL, S_MRUN, S_FIN, S_FIN2, S_EMIT,
        S_MUL, S_EU_TEST, S_EU_ALIGN, S_EU_SUB,
        S_PA_START, S_PA_TAN1, S_PA_TAN2, S_PA_TAN3, S_PA_INV,
        S_PA_LAM, S_PA_L2, S_PA_X, S_PA_X2, S_PA_Y, S_PA_Y2
    } state_t;

    function automatic logic [VW-1:0] mod_add(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                              input logic [VW-1:0] m);
        logic [VW:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, m})
                s = s - {1'b0, m};
            return s[VW-1:0];
        end
    endfunction

    function automatic logic [VW-1:0] mod_sub(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                              input logic [VW-1:0] m);
        logic [VW-1:0] d;
        begin
            d = a - b;
            if (a < b)
                d = d + m;
            return d;
        end
    endfunction

    state_t state_reg, mul_ret_reg, eu_ret_reg, pa_ret_reg;

    logic [COORD_BITS-1:0] curve_a_reg, curve_b_reg, field_prime_reg, base_x_reg, base_y_reg;
    logic [ORDER_BITS-1:0] group_order_reg;

    logic [VW-1:0] c_reg, d_reg, f_reg, wx_reg, wy_reg;
    logic          winf_reg;
    logic [VW-1:0] mod_reg, a_red_reg, gx_reg, gy_reg, h_reg, h1_reg, h2_reg;
    logic [2:0]    prep_idx_reg;
    logic [VW-1:0] k_reg;
    logic          phase_reg;

    logic [VW-1:0] ax_reg, ay_reg, rx_reg, ry_reg, v1x_reg, v1y_reg;
    logic          ainf_reg, rinf_reg, v1inf_reg;
    logic [VW-1:0] px_reg, py_reg, qx_reg, qy_reg, x3_reg, y3_reg;
    logic          pinf_reg, qinf_reg, inf3_reg;
    logic [VW-1:0] num_reg, den_reg, lam_reg, s_reg, inv_reg;

    logic [VW-1:0] ma_reg, mb_reg, macc_reg;
    logic [CW-1:0] mcnt_reg;

    logic [VW-1:0] uu_reg, vv_reg, rem_reg;
    logic [VW:0]   dv_reg;
    logic [SW-1:0] r0_reg, r1_reg, s1_reg, eacc_reg;
    logic [CW-1:0] ek_reg;

    logic          out_valid_reg;
    logic [1:0]    status_reg, res_status_reg;
    logic [ORDER_BITS-1:0] out_c_reg, res_c_reg;

    logic [VW+1:0] mul_t;
    logic [VW-1:0] macc_next;
    logic          rem_ge;
    logic [VW-1:0] rem_next;
    logic [SW-1:0] eacc_next, inv_fix;
    logic          domain_bad;
    logic [VW-1:0] field_w, order_w, prep_sel;

    assign field_w = VW'(field_prime_reg);
    assign order_w = VW'(group_order_reg);

    always_comb
    begin
        mul_t = {1'b0, macc_reg, 1'b0} + (mb_reg[VW-1] ? {2'b0, ma_reg} : '0);
        if (mul_t >= {1'b0, mod_reg, 1'b0})
            mul_t = mul_t - {1'b0, mod_reg, 1'b0};
        else if (mul_t >= {2'b0, mod_reg})
            mul_t = mul_t - {2'b0, mod_reg};
        macc_next = mul_t[VW-1:0];

        rem_ge    = {1'b0, rem_reg} >= dv_reg;
        rem_next  = rem_ge ? rem_reg - dv_reg[VW-1:0] : rem_reg;
        eacc_next = rem_ge ? eacc_reg - s1_reg : eacc_reg;
        inv_fix   = r0_reg[SW-1] ? r0_reg + {2'b0, mod_reg} : r0_reg;

        domain_bad = (64'(field_prime_reg) < ecdsa_pkg::MIN_MOD)
                  || (64'(field_prime_reg) > ecdsa_pkg::MAX_FIELD)
                  || (64'(group_order_reg) < ecdsa_pkg::MIN_MOD)
                  || (64'(group_order_reg) > ecdsa_pkg::MAX_ORDER)
                  || (c_reg == '0) || (c_reg >= order_w)
                  || (d_reg == '0) || (d_reg >= order_w);

        case (prep_idx_reg)
            3'd0:    prep_sel = VW'(curve_a_reg);
            3'd1:    prep_sel = VW'(base_x_reg);
            3'd2:    prep_sel = VW'(base_y_reg);
            3'd3:    prep_sel = wx_reg;
            default: prep_sel = wy_reg;
        endcase
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign recomputed_c = out_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mul_ret_reg     <= S_IDLE;
            eu_ret_reg      <= S_IDLE;
            pa_ret_reg      <= S_IDLE;
            curve_a_reg     <= COORD_BITS'(ecdsa_pkg::CURVE_A_RST);
            curve_b_reg     <= COORD_BITS'(ecdsa_pkg::CURVE_B_RST);
            field_prime_reg <= COORD_BITS'(ecdsa_pkg::FIELD_PRIME_RST);
            base_x_reg      <= COORD_BITS'(ecdsa_pkg::BASE_X_RST);
            base_y_reg      <= COORD_BITS'(ecdsa_pkg::BASE_Y_RST);
            group_order_reg <= ORDER_BITS'(ecdsa_pkg::GROUP_ORDER_RST);
            c_reg <= '0; d_reg <= '0; f_reg <= '0; wx_reg <= '0; wy_reg <= '0;
            winf_reg <= 1'b0;
            mod_reg <= '0; a_red_reg <= '0; gx_reg <= '0; gy_reg <= '0;
            h_reg <= '0; h1_reg <= '0; h2_reg <= '0;
            prep_idx_reg <= '0; k_reg <= '0; phase_reg <= 1'b0;
            ax_reg <= '0; ay_reg <= '0; ainf_reg <= 1'b1;
            rx_reg <= '0; ry_reg <= '0; rinf_reg <= 1'b1;
            v1x_reg <= '0; v1y_reg <= '0; v1inf_reg <= 1'b1;
            px_reg <= '0; py_reg <= '0; pinf_reg <= 1'b1;
            qx_reg <= '0; qy_reg <= '0; qinf_reg <= 1'b1;
            x3_reg <= '0; y3_reg <= '0; inf3_reg <= 1'b1;
            num_reg <= '0; den_reg <= '0; lam_reg <= '0; s_reg <= '0; inv_reg <= '0;
            ma_reg <= '0; mb_reg <= '0; macc_reg <= '0; mcnt_reg <= '0;
            uu_reg <= '0; vv_reg <= '0; rem_reg <= '0; dv_reg <= '0;
            r0_reg <= '0; r1_reg <= '0; s1_reg <= '0; eacc_reg <= '0; ek_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= ecdsa_pkg::ST_VALID;
            res_status_reg <= ecdsa_pkg::ST_VALID;
            out_c_reg <= '0;
            res_c_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ecdsa_pkg::REG_CURVE_A:     curve_a_reg     <= cfg_data[COORD_BITS-1:0];
                    ecdsa_pkg::REG_CURVE_B:     curve_b_reg     <= cfg_data[COORD_BITS-1:0];
                    ecdsa_pkg::REG_FIELD_PRIME: field_prime_reg <= cfg_data[COORD_BITS-1:0];
                    ecdsa_pkg::REG_BASE_X:      base_x_reg      <= cfg_data[COORD_BITS-1:0];
                    ecdsa_pkg::REG_BASE_Y:      base_y_reg      <= cfg_data[COORD_BITS-1:0];
                    ecdsa_pkg::REG_GROUP_ORDER: group_order_reg <= cfg_data[ORDER_BITS-1:0];
                    default: ;
                endcase
            end

            // The emit step drives the output valid itself
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        c_reg    <= VW'(sig_c);
                        d_reg    <= VW'(sig_d);
                        f_reg    <= VW'(message_hash);
                        wx_reg   <= VW'(pubkey_x);
                        wy_reg   <= VW'(pubkey_y);
                        winf_reg <= pubkey_at_infinity;
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    if (domain_bad)
                    begin
                        res_status_reg <= ecdsa_pkg::ST_DOMAIN;
                        res_c_reg      <= '0;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        mod_reg      <= field_w;
                        prep_idx_reg <= '0;
                        state_reg    <= S_PREP;
                    end
                end

                // Reduce a, G and W modulo the field prime as 1 * value
                S_PREP:
                begin
                    ma_reg <= VW'(1); mb_reg <= prep_sel; macc_reg <= '0;
                    mcnt_reg <= CW'(VW); mul_ret_reg <= S_PREP_WR; state_reg <= S_MUL;
                end

                S_PREP_WR:
                begin
                    case (prep_idx_reg)
                        3'd0:    a_red_reg <= macc_reg;
                        3'd1:    gx_reg    <= macc_reg;
                        3'd2:    gy_reg    <= macc_reg;
                        3'd3:    wx_reg    <= macc_reg;
                        default: wy_reg    <= macc_reg;
                    endcase
                    if (prep_idx_reg == 3'd4)
                        state_reg <= S_HINV;
                    else
                    begin
                        prep_idx_reg <= prep_idx_reg + 3'd1;
                        state_reg    <= S_PREP;
                    end
                end

                S_HINV:
                begin
                    mod_reg <= order_w;
                    uu_reg <= order_w; vv_reg <= d_reg;
                    r0_reg <= '0; r1_reg <= SW'(1);
                    eu_ret_reg <= S_H1; state_reg <= S_EU_TEST;
                end

                S_H1:
                begin
                    h_reg <= inv_reg;
                    ma_reg <= inv_reg; mb_reg <= f_reg; macc_reg <= '0;
                    mcnt_reg <= CW'(VW); mul_ret_reg <= S_H2; state_reg <= S_MUL;
                end

                S_H2:
                begin
                    h1_reg <= macc_reg;
                    ma_reg <= h_reg; mb_reg <= c_reg; macc_reg <= '0;
                    mcnt_reg <= CW'(VW); mul_ret_reg <= S_H3; state_reg <= S_MUL;
                end

                S_H3:
                begin
                    h2_reg <= macc_reg;
                    mod_reg <= field_w;
                    ainf_reg <= 1'b1; ax_reg <= '0; ay_reg <= '0;
                    rx_reg <= gx_reg; ry_reg <= gy_reg; rinf_reg <= 1'b0;
                    k_reg <= h1_reg; phase_reg <= 1'b0;
                    state_reg <= S_MLOOP;
                end

                S_MLOOP:
                begin
                    if (k_reg == '0)
                    begin
                        if (!phase_reg)
                        begin
                            v1x_reg <= ax_reg; v1y_reg <= ay_reg; v1inf_reg <= ainf_reg;
                            ainf_reg <= 1'b1; ax_reg <= '0; ay_reg <= '0;
                            rx_reg <= wx_reg; ry_reg <= wy_reg; rinf_reg <= winf_reg;
                            k_reg <= h2_reg; phase_reg <= 1'b1;
                        end
                        else
                        begin
                            px_reg <= v1x_reg; py_reg <= v1y_reg; pinf_reg <= v1inf_reg;
                            qx_reg <= ax_reg; qy_reg <= ay_reg; qinf_reg <= ainf_reg;
                            pa_ret_reg <= S_FIN; state_reg <= S_PA_START;
                        end
                    end
                    else if (k_reg[0])
                    begin
                        px_reg <= ax_reg; py_reg <= ay_reg; pinf_reg <= ainf_reg;
                        qx_reg <= rx_reg; qy_reg <= ry_reg; qinf_reg <= rinf_reg;
                        pa_ret_reg <= S_MACC; state_reg <= S_PA_START;
                    end
                    else
                        state_reg <= S_MDBL;
                end

                S_MACC:
                begin
                    ax_reg <= x3_reg; ay_reg <= y3_reg; ainf_reg <= inf3_reg;
                    state_reg <= S_MDBL;
                end

                S_MDBL:
                begin
                    px_reg <= rx_reg; py_reg <= ry_reg; pinf_reg <= rinf_reg;
                    qx_reg <= rx_reg; qy_reg <= ry_reg; qinf_reg <= rinf_reg;
                    pa_ret_reg <= S_MRUN; state_reg <= S_PA_START;
                end

                S_MRUN:
                begin
                    rx_reg <= x3_reg; ry_reg <= y3_reg; rinf_reg <= inf3_reg;
                    k_reg <= k_reg >> 1;
                    state_reg <= S_MLOOP;
                end

                S_FIN:
                begin
                    if (inf3_reg)
                    begin
                        res_status_reg <= ecdsa_pkg::ST_MISMATCH;
                        res_c_reg      <= '0;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        mod_reg <= order_w;
                        ma_reg <= VW'(1); mb_reg <= x3_reg; macc_reg <= '0;
                        mcnt_reg <= CW'(VW); mul_ret_reg <= S_FIN2; state_reg <= S_MUL;
                    end
                end

                S_FIN2:
                begin
                    res_c_reg      <= macc_reg[ORDER_BITS-1:0];
                    res_status_reg <= (macc_reg == c_reg) ? ecdsa_pkg::ST_VALID
                                                          : ecdsa_pkg::ST_MISMATCH;
                    state_reg      <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        out_c_reg     <= res_c_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                // Interleaved multiply: one multiplier bit per cycle, MSB first
                S_MUL:
                begin
                    macc_reg <= macc_next;
                    mb_reg   <= mb_reg << 1;
                    mcnt_reg <= mcnt_reg - CW'(1);
                    if (mcnt_reg == CW'(1))
                        state_reg <= mul_ret_reg;
                end

                S_EU_TEST:
                begin
                    if (vv_reg == '0)
                    begin
                        if (uu_reg != VW'(1))
                        begin
                            res_status_reg <= ecdsa_pkg::ST_NOINV;
                            res_c_reg      <= '0;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            inv_reg   <= inv_fix[VW-1:0];
                            state_reg <= eu_ret_reg;
                        end
                    end
                    else
                    begin
                        dv_reg <= {1'b0, vv_reg}; rem_reg <= uu_reg;
                        s1_reg <= r1_reg; eacc_reg <= r0_reg; ek_reg <= '0;
                        state_reg <= S_EU_ALIGN;
                    end
                end

                // Scale divisor up to the top quotient bit
                S_EU_ALIGN:
                begin
                    if ({dv_reg, 1'b0} <= {2'b0, rem_reg})
                    begin
                        dv_reg <= dv_reg << 1;
                        s1_reg <= s1_reg <<< 1;
                        ek_reg <= ek_reg + CW'(1);
                    end
                    else
                        state_reg <= S_EU_SUB;
                end

                // One quotient bit per cycle; fold q*r1 into the coefficient as we go
                S_EU_SUB:
                begin
                    if (ek_reg == '0)
                    begin
                        uu_reg <= vv_reg; vv_reg <= rem_next;
                        r0_reg <= r1_reg; r1_reg <= eacc_next;
                        state_reg <= S_EU_TEST;
                    end
                    else
                    begin
                        rem_reg <= rem_next; eacc_reg <= eacc_next;
                        dv_reg <= dv_reg >> 1;
                        s1_reg <= $signed(s1_reg) >>> 1;
                        ek_reg <= ek_reg - CW'(1);
                    end
                end

                S_PA_START:
                begin
                    if (pinf_reg)
                    begin
                        x3_reg <= qx_reg; y3_reg <= qy_reg; inf3_reg <= qinf_reg;
                        state_reg <= pa_ret_reg;
                    end
                    else if (qinf_reg)
                    begin
                        x3_reg <= px_reg; y3_reg <= py_reg; inf3_reg <= 1'b0;
                        state_reg <= pa_ret_reg;
                    end
                    else if (px_reg != qx_reg)
                    begin
                        num_reg <= mod_sub(py_reg, qy_reg, mod_reg);
                        den_reg <= mod_sub(px_reg, qx_reg, mod_reg);
                        state_reg <= S_PA_INV;
                    end
                    else if (py_reg == qy_reg && py_reg != '0)
                    begin
                        ma_reg <= px_reg; mb_reg <= px_reg; macc_reg <= '0;
                        mcnt_reg <= CW'(VW); mul_ret_reg <= S_PA_TAN1; state_reg <= S_MUL;
                    end
                    else
                    begin
                        x3_reg <= '0; y3_reg <= '0; inf3_reg <= 1'b1;
                        state_reg <= pa_ret_reg;
                    end
                end

                S_PA_TAN1:
                begin
                    s_reg <= macc_reg;
                    num_reg <= mod_add(macc_reg, macc_reg, mod_reg);
                    state_reg <= S_PA_TAN2;
                end

                S_PA_TAN2:
                begin
                    num_reg <= mod_add(num_reg, s_reg, mod_reg);
                    state_reg <= S_PA_TAN3;
                end

                S_PA_TAN3:
                begin
                    num_reg <= mod_add(num_reg, a_red_reg, mod_reg);
                    den_reg <= mod_add(py_reg, py_reg, mod_reg);
                    state_reg <= S_PA_INV;
                end

                S_PA_INV:
                begin
                    uu_reg <= mod_reg; vv_reg <= den_reg;
                    r0_reg <= '0; r1_reg <= SW'(1);
                    eu_ret_reg <= S_PA_LAM; state_reg <= S_EU_TEST;
                end

                S_PA_LAM:
                begin
                    ma_reg <= num_reg; mb_reg <= inv_reg; macc_reg <= '0;
                    mcnt_reg <= CW'(VW); mul_ret_reg <= S_PA_L2; state_reg <= S_MUL;
                end

                S_PA_L2:
                begin
                    lam_reg <= macc_reg;
                    ma_reg <= macc_reg; mb_reg <= macc_reg; macc_reg <= '0;
                    mcnt_reg <= CW'(VW); mul_ret_reg <= S_PA_X; state_reg <= S_MUL;
                end

                S_PA_X:
                begin
                    s_reg <= mod_sub(macc_reg, px_reg, mod_reg);
                    state_reg <= S_PA_X2;
                end

                S_PA_X2:
                begin
                    x3_reg <= mod_sub(s_reg, qx_reg, mod_reg);
                    state_reg <= S_PA_Y;
                end

                S_PA_Y:
                begin
                    ma_reg <= lam_reg; mb_reg <= mod_sub(px_reg, x3_reg, mod_reg);
                    macc_reg <= '0; mcnt_reg <= CW'(VW);
                    mul_ret_reg <= S_PA_Y2; state_reg <= S_MUL;
                end

                S_PA_Y2:
                begin
                    y3_reg <= mod_sub(macc_reg, py_reg, mod_reg);
                    inf3_reg <= 1'b0;
                    state_reg <= pa_ret_reg;
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (macc_reg < mod_reg))
        else $error("multiplier accumulator left the residue range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EU_SUB || state_reg == S_EU_ALIGN) |-> (dv_reg != '0))
        else $error("Euclid divisor is zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ecdsa_pkg::ST_DOMAIN
                           || status_reg == ecdsa_pkg::ST_NOINV)) |-> (out_c_reg == '0))
        else $error("nonzero recomputed value on an error status");

endmodule

@@ tb/ecdsa_signature_verify_tb.sv @@
module ecdsa_signature_verify_tb;

    localparam int CB = ecdsa_pkg::COORD_BITS_DEF;
    localparam int OB = ecdsa_pkg::ORDER_BITS_DEF;
    localparam int STALL_LIMIT = 500000;

    typedef struct {
        longint x;
        longint y;
        bit     inf;
    } ec_pt_t;

    typedef struct {
        logic [1:0]    st;
        logic [OB-1:0] rc;
    } verdict_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [CB-1:0] pubkey_x;
    logic [CB-1:0] pubkey_y;
    logic          pubkey_at_infinity;
    logic [OB-1:0] message_hash;
    logic [OB-1:0] sig_c;
    logic [OB-1:0] sig_d;
    logic          out_valid;
    logic          out_ready;
    logic [1:0]    status;
    logic [OB-1:0] recomputed_c;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_index;
    logic [OB-1:0] cfg_data;

    ecdsa_signature_verify dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pubkey_x(pubkey_x), .pubkey_y(pubkey_y),
        .pubkey_at_infinity(pubkey_at_infinity),
        .message_hash(message_hash), .sig_c(sig_c), .sig_d(sig_d),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .recomputed_c(recomputed_c),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow registers
    longint reg_a;
    longint reg_b;
    longint reg_p;
    longint reg_gx;
    longint reg_gy;
    longint reg_r;

    // per-verification scratch
    longint fld_n;
    longint a_red;
    bit     no_inv;

    verdict_t verdicts[$];
    int       errors;
    int       send_idle;
    int       recv_stall;
    int       quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint md(longint v, longint m);
        longint t;
        t = v % m;
        if (t < 0)
            t = t + m;
        return t;
    endfunction

    function automatic longint inv_mod(longint v, longint m);
        longint uu, vv, r0, r1, q, t;
        uu = m;
        vv = v;
        r0 = 0;
        r1 = 1;
        if (vv < 0)
            vv = vv + m;
        while (vv != 0)
        begin
            q = uu / vv;
            t = uu - q * vv;
            uu = vv;
            vv = t;
            t = r0 - q * r1;
            r0 = r1;
            r1 = t;
        end
        if (uu != 1)
            no_inv = 1'b1;
        return r0;
    endfunction

    function automatic ec_pt_t pt_add(ec_pt_t p, ec_pt_t q);
        ec_pt_t res;
        longint lam, t;
        res.x = 0;
        res.y = 0;
        res.inf = 1'b1;
        if (p.inf)
            return q;
        if (q.inf)
            return p;
        if (p.x != q.x)
        begin
            lam = md((p.y - q.y) * inv_mod(p.x - q.x, fld_n), fld_n);
        end
        else if (p.y == q.y && p.y != 0)
        begin
            t = md(3 * md(p.x * p.x, fld_n) + a_red, fld_n);
            lam = md(t * inv_mod(2 * p.y, fld_n), fld_n);
        end
        else
        begin
            return res;
        end
        t = md(lam * lam - p.x - q.x, fld_n);
        res.y = md(lam * (p.x - t) - p.y, fld_n);
        res.x = t;
        res.inf = 1'b0;
        if (no_inv)
        begin
            res.x = 0;
            res.y = 0;
            res.inf = 1'b1;
        end
        return res;
    endfunction

    function automatic ec_pt_t pt_mul(ec_pt_t p, longint k);
        ec_pt_t acc, run;
        run = p;
        acc.x = 0;
        acc.y = 0;
        acc.inf = 1'b1;
        while (k != 0)
        begin
            if (k[0])
                acc = pt_add(acc, run);
            if (no_inv)
            begin
                acc.x = 0;
                acc.y = 0;
                acc.inf = 1'b1;
                break;
            end
            run = pt_add(run, run);
            k = k >> 1;
        end
        return acc;
    endfunction

    function automatic bit curve_ok();
        return !(reg_p < 5 || reg_p > ecdsa_pkg::MAX_FIELD
                 || reg_r < 5 || reg_r > ecdsa_pkg::MAX_ORDER);
    endfunction

    function automatic ec_pt_t base_point();
        ec_pt_t g;
        fld_n = reg_p;
        a_red = md(reg_a, fld_n);
        g.x = md(reg_gx, fld_n);
        g.y = md(reg_gy, fld_n);
        g.inf = 1'b0;
        return g;
    endfunction

    function automatic verdict_t verify_sig(logic [CB-1:0] wx, logic [CB-1:0] wy, bit winf,
                                            logic [OB-1:0] f_in, logic [OB-1:0] c_in,
                                            logic [OB-1:0] d_in);
        verdict_t vd;
        longint c, d, h, h1, h2, cx;
        ec_pt_t g, w, v1, v2;
        vd.st = ecdsa_pkg::ST_DOMAIN;
        vd.rc = '0;
        no_inv = 1'b0;
        if (!curve_ok())
            return vd;
        c = c_in;
        d = d_in;
        if (!(c > 0 && c < reg_r && d > 0 && d < reg_r))
            return vd;
        g = base_point();
        w.x = winf ? 0 : md(wx, fld_n);
        w.y = winf ? 0 : md(wy, fld_n);
        w.inf = winf;
        h = inv_mod(d, reg_r);
        h1 = md(longint'(f_in) * h, reg_r);
        h2 = md(c * h, reg_r);
        v1 = pt_mul(g, h1);
        v2 = pt_mul(w, h2);
        v1 = pt_add(v1, v2);
        if (no_inv)
        begin
            vd.st = ecdsa_pkg::ST_NOINV;
        end
        else if (v1.inf)
        begin
            vd.st = ecdsa_pkg::ST_MISMATCH;
        end
        else
        begin
            cx = md(v1.x, reg_r);
            vd.rc = OB'(cx);
            vd.st = (cx == c) ? ecdsa_pkg::ST_VALID : ecdsa_pkg::ST_MISMATCH;
        end
        return vd;
    endfunction

    // With the key at infinity V depends only on f/d, so c can be made to match.
    function automatic logic [OB-1:0] forge_c(logic [OB-1:0] f_in, logic [OB-1:0] d_in);
        longint h, cx;
        ec_pt_t v;
        no_inv = 1'b0;
        if (!curve_ok() || d_in == 0 || d_in >= reg_r)
            return '0;
        v = base_point();
        h = inv_mod(d_in, reg_r);
        v = pt_mul(v, md(longint'(f_in) * h, reg_r));
        if (no_inv || v.inf)
            return '0;
        cx = md(v.x, reg_r);
        return OB'(cx);
    endfunction

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        verdict_t ev;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts.size() == 0)
            begin
                $display("%0t: unexpected beat status=%0d recomputed_c=%0d",
                         $time, status, recomputed_c);
                errors++;
            end
            else
            begin
                ev = verdicts.pop_front();
                if (status !== ev.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, ev.st, status);
                    errors++;
                end
                if (recomputed_c !== ev.rc)
                begin
                    $display("%0t: recomputed_c expected %0d actual %0d",
                             $time, ev.rc, recomputed_c);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_sig(logic [CB-1:0] wx, logic [CB-1:0] wy, bit winf,
                            logic [OB-1:0] f, logic [OB-1:0] c, logic [OB-1:0] d);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pubkey_x <= wx;
        pubkey_y <= wy;
        pubkey_at_infinity <= winf;
        message_hash <= f;
        sig_c <= c;
        sig_d <= d;
        verdicts.push_back(verify_sig(wx, wy, winf, f, c, d));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (verdicts.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [OB-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            ecdsa_pkg::REG_CURVE_A:     reg_a = val[CB-1:0];
            ecdsa_pkg::REG_CURVE_B:     reg_b = val[CB-1:0];
            ecdsa_pkg::REG_FIELD_PRIME: reg_p = val[CB-1:0];
            ecdsa_pkg::REG_BASE_X:      reg_gx = val[CB-1:0];
            ecdsa_pkg::REG_BASE_Y:      reg_gy = val[CB-1:0];
            ecdsa_pkg::REG_GROUP_ORDER: reg_r = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic rand_curve();
        longint primes[8] = '{5, 7, 101, 1009, 65521, 1000003, 1001, 1073741789};
        drain();
        cfg_write(ecdsa_pkg::REG_CURVE_A, OB'($urandom()));
        cfg_write(ecdsa_pkg::REG_CURVE_B, OB'($urandom()));
        cfg_write(ecdsa_pkg::REG_FIELD_PRIME, OB'(primes[$urandom_range(7)]));
        cfg_write(ecdsa_pkg::REG_BASE_X, OB'($urandom()));
        cfg_write(ecdsa_pkg::REG_BASE_Y, OB'($urandom()));
        // keep scalars short so most beats finish quickly
        cfg_write(ecdsa_pkg::REG_GROUP_ORDER, OB'($urandom_range(3000, 5)));
    endtask

    task automatic rand_sig();
        logic [OB-1:0] f, c, d;
        longint rr;
        int kind;
        rr = curve_ok() ? reg_r : 1000;
        kind = $urandom_range(9);
        f = OB'($urandom());
        c = OB'($urandom_range(rr - 1, 1));
        d = OB'($urandom_range(rr - 1, 1));
        if (kind <= 3)
        begin
            c = forge_c(f, d);
            if (c == 0)
                c = OB'($urandom_range(rr - 1, 1));
            send_sig(CB'($urandom()), CB'($urandom()), 1'b1, f, c, d);
        end
        else if (kind <= 6)
        begin
            send_sig(CB'($urandom()), CB'($urandom()), 1'b0, f, c, d);
        end
        else if (kind <= 8)
        begin
            send_sig(CB'($urandom()), CB'($urandom()), 1'($urandom_range(1)), f,
                     OB'($urandom()), OB'($urandom()));
        end
        else
        begin
            case ($urandom_range(3))
                0: c = 0;
                1: d = OB'(rr);
                2: c = OB'(rr - 1);
                default: d = {OB{1'b1}};
            endcase
            send_sig(CB'($urandom()), CB'($urandom()), 1'($urandom_range(1)), f, c, d);
        end
    endtask

    task automatic test_reset_curve();
        logic [OB-1:0] c;
        // out of domain
        send_sig('0, '0, 1'b0, '0, '0, 31'd5);
        send_sig('1, '1, 1'b1, '1, '1, '1);
        send_sig(30'd7, 30'd9, 1'b0, 31'd3, OB'(reg_r), 31'd1);
        // smallest and largest in-range signature parts
        send_sig({CB{1'b1}}, {CB{1'b1}}, 1'b0, {OB{1'b1}}, 31'd1, OB'(reg_r - 1));
        c = forge_c(31'd12345, 31'd777);
        send_sig('0, '0, 1'b1, 31'd12345, c, 31'd777);
        send_sig(30'd13693, 30'd10088, 1'b0, 31'd1, 31'd1, 31'd1);
    endtask

    task automatic test_special_cases();
        logic [OB-1:0] c;
        drain();
        cfg_write(ecdsa_pkg::REG_CURVE_A, {OB{1'b1}});
        cfg_write(ecdsa_pkg::REG_FIELD_PRIME, 31'd101);
        cfg_write(ecdsa_pkg::REG_BASE_X, 31'd205);
        cfg_write(ecdsa_pkg::REG_BASE_Y, 31'd0);
        cfg_write(ecdsa_pkg::REG_GROUP_ORDER, 31'd97);
        // doubling a point with y zero lands at infinity
        send_sig('0, '0, 1'b1, 31'd2, 31'd5, 31'd1);
        // key equal to G and its negation: equal x
        send_sig(30'd205, 30'd0, 1'b0, 31'd1, 31'd1, 31'd1);
        drain();
        cfg_write(ecdsa_pkg::REG_BASE_Y, 31'd17);
        send_sig(30'd104, 30'd84, 1'b0, 31'd1, 31'd1, 31'd1);
        send_sig(30'd3, 30'd17, 1'b0, 31'd1, 31'd1, 31'd1);
        c = forge_c(31'd40, 31'd3);
        send_sig(CB'($urandom()), CB'($urandom()), 1'b1, 31'd40, c, 31'd3);
        // composite order: d sharing a factor has no inverse
        drain();
        cfg_write(ecdsa_pkg::REG_GROUP_ORDER, 31'd100);
        send_sig(30'd1, 30'd2, 1'b0, 31'd9, 31'd3, 31'd10);
        send_sig(30'd1, 30'd2, 1'b0, 31'd9, 31'd3, 31'd99);
        // composite field: a denominator without inverse
        drain();
        cfg_write(ecdsa_pkg::REG_FIELD_PRIME, 31'd1001);
        send_sig(30'd7, 30'd5, 1'b0, 31'd11, 31'd3, 31'd7);
        send_sig(30'd212, 30'd6, 1'b0, 31'd1, 31'd1, 31'd1);
    endtask

    task automatic test_domain_bounds();
        drain();
        cfg_write(ecdsa_pkg::REG_FIELD_PRIME, 31'd4);
        send_sig(30'd1, 30'd1, 1'b0, 31'd1, 31'd1, 31'd1);
        drain();
        cfg_write(ecdsa_pkg::REG_FIELD_PRIME, OB'(ecdsa_pkg::MAX_FIELD + 1));
        send_sig(30'd1, 30'd1, 1'b0, 31'd1, 31'd1, 31'd1);
        drain();
        cfg_write(ecdsa_pkg::REG_FIELD_PRIME, 31'd5);
        cfg_write(ecdsa_pkg::REG_GROUP_ORDER, 31'd4);
        send_sig(30'd1, 30'd1, 1'b0, 31'd1, 31'd1, 31'd1);
        drain();
        cfg_write(ecdsa_pkg::REG_GROUP_ORDER, OB'(ecdsa_pkg::MAX_ORDER + 1));
        send_sig(30'd1, 30'd1, 1'b0, 31'd1, 31'd1, 31'd1);
        drain();
        cfg_write(ecdsa_pkg::REG_GROUP_ORDER, {OB{1'b1}});
        send_sig(30'd1, 30'd1, 1'b0, 31'd1, 31'd1, 31'd1);
        drain();
        cfg_write(ecdsa_pkg::REG_GROUP_ORDER, 31'd5);
        send_sig(30'd4, 30'd3, 1'b0, 31'd2, 31'd4, 31'd4);
    endtask

    task automatic test_random_phase(int idle, int stall, int n);
        send_idle = idle;
        recv_stall = stall;
        rand_curve();
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain();
            rand_sig();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        pubkey_x = '0;
        pubkey_y = '0;
        pubkey_at_infinity = 1'b0;
        message_hash = '0;
        sig_c = '0;
        sig_d = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = ecdsa_pkg::REG_CURVE_A;
        cfg_data = '0;
        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        quiet_cycles = 0;
        reg_a = ecdsa_pkg::CURVE_A_RST;
        reg_b = ecdsa_pkg::CURVE_B_RST;
        reg_p = ecdsa_pkg::FIELD_PRIME_RST;
        reg_gx = ecdsa_pkg::BASE_X_RST;
        reg_gy = ecdsa_pkg::BASE_Y_RST;
        reg_r = ecdsa_pkg::GROUP_ORDER_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_curve();
        test_special_cases();
        test_domain_bounds();
        test_random_phase(0, 0, 20);
        test_random_phase(47, 0, 20);
        test_random_phase(0, 47, 20);
        test_random_phase(19, 19, 20);

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
